### src/b32e_pkg.sv
// shared types, constants and lookup functions of the base32 stream encoder
`default_nettype none
package b32e_pkg;

  localparam logic [7:0] PAD_CHAR    = 8'h3D;
  localparam logic [3:0] GROUP_CHARS = 4'd8;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [4:0] code0;
    logic [4:0] code1;
    logic [4:0] code2;
    logic [1:0] nchars;
    logic [2:0] npad;
    logic       eom;
  } job_t;

  function automatic logic [7:0] alphabet(input logic [4:0] code);
    logic [7:0] ch;
    if (code < 5'd26) begin
      ch = 8'h41 + {3'b000, code};
    end else begin
      ch = 8'h32 + {3'b000, code - 5'd26};
    end
    return ch;
  endfunction

  function automatic logic [2:0] chars_before(input logic [2:0] pos);
    logic [2:0] n;
    case (pos)
      3'd0: n = 3'd0;
      3'd1: n = 3'd1;
      3'd2: n = 3'd3;
      3'd3: n = 3'd4;
      3'd4: n = 3'd6;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

### src/base32_stream_encoder_unit.sv
// top level of the base32 stream encoder
//
// input queue side: data_byte and end_of_message are taken on a clock edge where
// push is high and full is low. one raw byte per item; end_of_message marks the
// final byte, which flushes leftover bits and pads the group with '='.
// output queue side: while empty is low, out_char holds the oldest character
// (last_char set on the final one of a message); it leaves on an edge with pop
// high and empty low.
// a byte yields one to eight characters. the back end emits one character per
// cycle while the output is popped, so throughput is set by the output: eight
// characters per five bytes. the first character of an item reaches the output
// through the queue entry, written on the accepting edge, and then the output
// register, which loads once the back end reaches that item.
// a four-entry job queue separates the front end from the character emitter,
// so bytes are still accepted while the output stalls; full rises once it fills.
// a stalled output holds its character. synchronous reset clears the
// accumulator, group position, queue and output valid flag.
`default_nettype none
module base32_stream_encoder_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_message,
  input  wire logic       push,
  output logic            full,
  output logic [7:0]      out_char,
  output logic            last_char,
  output logic            empty,
  input  wire logic       pop
);

  b32e_pkg::job_t new_job;
  b32e_pkg::job_t head_job;
  logic           accept;
  logic           q_empty;
  logic           job_done;

  assign accept = push && !full;

  b32e_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .job            (new_job)
  );

  b32e_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (new_job),
    .full    (full),
    .rd_en   (job_done),
    .rd_data (head_job),
    .empty   (q_empty)
  );

  b32e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .job_valid (!q_empty),
    .job_done  (job_done),
    .out_char  (out_char),
    .last_char (last_char),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
`default_nettype wire

### src/b32e_front.sv
// front end: bit accumulator, group tracking and per-item job classification
`default_nettype none
module b32e_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    data_byte,
  input  wire logic          end_of_message,
  output b32e_pkg::job_t     job
);

  logic [3:0]  acc;
  logic [2:0]  pending;
  logic [2:0]  pos;
  logic [3:0]  acc_next;
  logic [2:0]  pending_next;
  logic [2:0]  pos_next;

  logic [3:0]  bits;
  logic [3:0]  sh0;
  logic [3:0]  sh1;
  logic [2:0]  rem;
  logic [11:0] acc12;
  logic [11:0] shr0;
  logic [11:0] shr1;
  logic [11:0] shl;
  logic [2:0]  pos_eff;
  logic [1:0]  ndata;
  logic        fill;
  logic [1:0]  nchars;
  logic [3:0]  total;
  logic [3:0]  mask;

  always_comb begin
    bits    = ({1'b0, pending} + 4'd8 > 4'd12) ? 4'd12 : ({1'b0, pending} + 4'd8);
    acc12   = {acc, data_byte};
    sh0     = bits - 4'd5;
    shr0    = acc12 >> sh0;
    if (bits >= 4'd10) begin
      ndata = 2'd2;
      sh1   = bits - 4'd10;
    end else begin
      ndata = 2'd1;
      sh1   = 4'd0;
    end
    shr1    = acc12 >> sh1;
    rem     = (bits >= 4'd10) ? sh1[2:0] : sh0[2:0];
    shl     = acc12 << (3'd5 - rem);
    fill    = end_of_message && (rem != 3'd0);
    nchars  = ndata + {1'b0, fill};
    pos_eff = (pos > 3'd4) ? 3'd0 : pos;
    total   = {1'b0, b32e_pkg::chars_before(pos_eff)} + {2'b00, nchars};
    mask    = 4'((5'd1 << rem) - 5'd1);

    job.code0  = shr0[4:0];
    job.code1  = (ndata == 2'd2) ? shr1[4:0] : shl[4:0];
    job.code2  = shl[4:0];
    job.nchars = nchars;
    job.npad   = (end_of_message && total < b32e_pkg::GROUP_CHARS) ?
                 3'(b32e_pkg::GROUP_CHARS - total) : 3'd0;
    job.eom    = end_of_message;

    if (end_of_message) begin
      acc_next     = 4'd0;
      pending_next = 3'd0;
      pos_next     = 3'd0;
    end else begin
      acc_next     = acc12[3:0] & mask;
      pending_next = rem;
      pos_next     = (pos_eff >= 3'd4) ? 3'd0 : pos_eff + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= 4'd0;
      pending <= 3'd0;
      pos     <= 3'd0;
    end else if (accept) begin
      acc     <= acc_next;
      pending <= pending_next;
      pos     <= pos_next;
    end
  end

endmodule
`default_nettype wire

### src/b32e_queue.sv
// short job queue between front and back end
`default_nettype none
module b32e_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  b32e_pkg::job_t     wr_data,
  output logic               full,
  input  wire logic          rd_en,
  output b32e_pkg::job_t     rd_data,
  output logic               empty
);

  b32e_pkg::job_t                  entries [b32e_pkg::QUEUE_DEPTH];
  logic [b32e_pkg::QUEUE_AW-1:0]   wr_ptr;
  logic [b32e_pkg::QUEUE_AW-1:0]   rd_ptr;
  logic [b32e_pkg::QUEUE_AW:0]     count;
  logic                            do_wr;
  logic                            do_rd;

  assign full    = (count == (b32e_pkg::QUEUE_AW+1)'(b32e_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### src/b32e_back.sv
// back end: job to characters in an output register, one per cycle unless stalled
`default_nettype none
module b32e_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  b32e_pkg::job_t     job,
  input  wire logic          job_valid,
  output logic               job_done,
  output logic [7:0]         out_char,
  output logic               last_char,
  output logic               empty,
  input  wire logic          pop
);

  logic [2:0] idx;
  logic [3:0] total;
  logic       last_idx;
  logic       fire;
  logic       out_valid;
  logic [4:0] code;
  logic [7:0] ch;

  always_comb begin
    total    = {2'b00, job.nchars} + {1'b0, job.npad};
    last_idx = ({1'b0, idx} == total - 4'd1);
    fire     = job_valid && (!out_valid || pop);
    job_done = fire && last_idx;
    case (idx[1:0])
      2'd0:    code = job.code0;
      2'd1:    code = job.code1;
      default: code = job.code2;
    endcase
    ch = ({1'b0, idx} < {2'b00, job.nchars}) ? b32e_pkg::alphabet(code) : b32e_pkg::PAD_CHAR;
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (fire) begin
      out_char  <= ch;
      last_char <= job.eom && last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        idx       <= last_idx ? 3'd0 : idx + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### tb/base32_stream_encoder_unit_test.sv
// self-checking testbench of the base32 stream encoder with a byte-level predictor
module base32_stream_encoder_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS   = 430;
  localparam int NUM_DIRECTED  = 25;
  localparam int HOLD_CYCLES   = 60;
  localparam int DRAIN_CYCLES  = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [8*32-1:0] SYMBOLS = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

  typedef struct packed {
    logic [3:0]  count;
    logic [63:0] chars;
  } encoded_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        eom;
    logic        typed;
    logic [3:0]  count;
    logic [63:0] chars;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_message = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] out_char;
  logic       last_char;
  logic       empty;
  logic       pop = 1'b0;

  logic [11:0] acc_bits = '0;
  logic [2:0]  pend_count = '0;
  logic [2:0]  grp_pos = '0;

  char_item_t expected_chars[$];
  int mismatches = 0;
  int send_idle_pct = 14;
  int recv_idle_pct = 56;
  int stall_cycles = 0;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{8'h00, 1'b1, 1'b1, 4'd8, "AA======"},
    '{8'hFF, 1'b1, 1'b1, 4'd8, "74======"},
    '{"f",   1'b0, 1'b1, 4'd1, "M"},
    '{"o",   1'b0, 1'b1, 4'd2, "ZX"},
    '{"o",   1'b0, 1'b1, 4'd1, "W"},
    '{"b",   1'b0, 1'b1, 4'd2, "6Y"},
    '{"a",   1'b0, 1'b1, 4'd2, "TB"},
    '{"r",   1'b1, 1'b1, 4'd8, "OI======"},
    '{"f",   1'b0, 1'b1, 4'd1, "M"},
    '{"o",   1'b1, 1'b1, 4'd7, "ZXQ===="},
    '{"f",   1'b0, 1'b1, 4'd1, "M"},
    '{"o",   1'b0, 1'b1, 4'd2, "ZX"},
    '{"o",   1'b1, 1'b1, 4'd5, "W6==="},
    '{"f",   1'b0, 1'b1, 4'd1, "M"},
    '{"o",   1'b0, 1'b1, 4'd2, "ZX"},
    '{"o",   1'b0, 1'b1, 4'd1, "W"},
    '{"b",   1'b1, 1'b1, 4'd4, "6YQ="},
    '{"f",   1'b0, 1'b1, 4'd1, "M"},
    '{"o",   1'b0, 1'b1, 4'd2, "ZX"},
    '{"o",   1'b0, 1'b1, 4'd1, "W"},
    '{"b",   1'b0, 1'b1, 4'd2, "6Y"},
    '{"a",   1'b1, 1'b1, 4'd2, "TB"},
    '{8'hFF, 1'b0, 1'b0, 4'd0, 64'd0},
    '{8'h80, 1'b0, 1'b0, 4'd0, 64'd0},
    '{8'h01, 1'b1, 1'b0, 4'd0, 64'd0}
  };

  base32_stream_encoder_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .push           (push),
    .full           (full),
    .out_char       (out_char),
    .last_char      (last_char),
    .empty          (empty),
    .pop            (pop)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] symbol(input logic [4:0] code);
    return SYMBOLS[8*(31 - int'(code)) +: 8];
  endfunction

  function automatic encoded_t encode_byte(input logic [7:0] b, input logic eom);
    encoded_t    r;
    logic [11:0] acc;
    logic [11:0] sh;
    int          nbits;
    int          total;
    r = '0;
    nbits = int'(pend_count) + 8;
    if (nbits > 12) nbits = 12;
    acc = {acc_bits[3:0], b};
    while (nbits >= 5) begin
      nbits -= 5;
      sh = acc >> nbits;
      r.chars = {r.chars[55:0], symbol(sh[4:0])};
      r.count = r.count + 4'd1;
    end
    if (eom) begin
      if (nbits > 0) begin
        sh = acc << (5 - nbits);
        r.chars = {r.chars[55:0], symbol(sh[4:0])};
        r.count = r.count + 4'd1;
      end
      total = (int'(grp_pos) * 8) / 5 + int'(r.count);
      while (total < int'(b32e_pkg::GROUP_CHARS) && r.count < 4'd8) begin
        r.chars = {r.chars[55:0], b32e_pkg::PAD_CHAR};
        r.count = r.count + 4'd1;
        total++;
      end
      acc_bits = '0;
      pend_count = '0;
      grp_pos = '0;
    end else begin
      acc_bits = acc & ((12'd1 << nbits) - 12'd1);
      pend_count = 3'(nbits);
      grp_pos = (grp_pos >= 3'd4) ? 3'd0 : grp_pos + 3'd1;
    end
    return r;
  endfunction

  task automatic queue_chars(input encoded_t r, input logic eom);
    char_item_t c;
    for (int k = 0; k < int'(r.count); k++) begin
      c.ch = r.chars[8*(int'(r.count) - 1 - k) +: 8];
      c.last = eom && (k == int'(r.count) - 1);
      expected_chars.push_back(c);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eom);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    end_of_message <= eom;
    do @(posedge clk); while (full);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void set_phase(input int sent);
    case ((sent * 3) / TOTAL_ITEMS)
      0: begin
        send_idle_pct = 14;
        recv_idle_pct = 56;
      end
      1: begin
        send_idle_pct = 56;
        recv_idle_pct = 14;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    char_item_t want;
    if (!rst && pop && !empty) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected char", out_char, 8'h00);
      end else begin
        want = expected_chars.pop_front();
        if (out_char !== want.ch) report_mismatch("out_char", out_char, want.ch);
        if (last_char !== want.last)
          report_mismatch("last_char", {7'd0, last_char}, {7'd0, want.last});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver, with one long hold-off right after reset to fill the block
  initial begin
    wait (!rst);
    repeat (HOLD_CYCLES) @(posedge clk);
    forever begin
      @(posedge clk);
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    encoded_t   r;
    stim_row_t  row;
    int         sent;
    int         msg_len;
    logic [7:0] b;
    logic       eom;
    sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      set_phase(sent);
      send_byte(row.data, row.eom);
      r = encode_byte(row.data, row.eom);
      if (row.typed) begin
        r.count = row.count;
        r.chars = row.chars;
      end
      queue_chars(r, row.eom);
      sent++;
    end
    while (sent < TOTAL_ITEMS) begin
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int k = 0; k < msg_len && sent < TOTAL_ITEMS; k++) begin
        set_phase(sent);
        b = pick_byte();
        eom = (k == msg_len - 1) || (sent == TOTAL_ITEMS - 1);
        send_byte(b, eom);
        queue_chars(encode_byte(b, eom), eom);
        sent++;
      end
    end
    push <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
